FILE: hdl/assert_macros.svh
// Assertion macros shared by the expander RTL.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");
// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/mie_pkg.sv
// Shared types and constants for the instruction expander.
// No dependencies.
package mie_pkg;

  localparam int unsigned MaxWords = 6;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned LenW     = 3;
  localparam int unsigned QDepth   = 2;

  localparam logic [4:0] OpAluLo = 5'd0;
  localparam logic [4:0] OpAluHi = 5'd7;
  localparam logic [4:0] OpMovi  = 5'd8;
  localparam logic [4:0] OpLoad  = 5'd9;
  localparam logic [4:0] OpStore = 5'd10;
  localparam logic [4:0] OpJmp   = 5'd11;
  localparam logic [4:0] OpJz    = 5'd12;
  localparam logic [4:0] OpJnz   = 5'd13;
  localparam logic [4:0] OpCall  = 5'd14;
  localparam logic [4:0] OpRet   = 5'd15;
  localparam logic [4:0] OpPush  = 5'd16;
  localparam logic [4:0] OpPop   = 5'd17;
  localparam logic [4:0] OpPushi = 5'd18;
  localparam logic [4:0] OpMov   = 5'd19;
  localparam logic [4:0] OpInc   = 5'd20;
  localparam logic [4:0] OpDec   = 5'd21;
  localparam logic [4:0] OpClr   = 5'd22;
  localparam logic [4:0] OpJe    = 5'd23;
  localparam logic [4:0] OpJne   = 5'd24;
  localparam logic [4:0] OpJlt   = 5'd25;

  // One expanded instruction: its words in order and how many are used.
  typedef struct packed {
    logic [MaxWords-1:0][15:0] words;
    logic [LenW-1:0]           len;
  } seq_t;

endpackage

FILE: hdl/macro_instruction_expander.sv
// Top level of the instruction expander: front decode, queue, back sequencer.
// Depends on mie_pkg, mie_front, mie_queue, mie_back and assert_macros.svh.
`include "assert_macros.svh"

// An instruction is taken as one beat when start is high and busy is low.
// Each taken beat of opcodes 0 to 25 expands into one to six 16-bit words,
// shown on machine_word_o one per cycle with result_strobe_o high; last_word_o
// marks the final word of each instruction. Opcodes 26 to 31 are taken and
// produce no words. The receiver cannot stall, so words leave at a steady
// one per cycle: when the block is empty, the first word of a beat is
// written into the queue and then loaded into the sequencer's register
// before it reaches the outputs, and the words of an instruction leave back
// to back. The single output port sets the sustained throughput. A two-entry
// queue sits between the decoder and the output sequencer, so new beats are
// taken while earlier ones are still being emitted; busy rises only when
// that queue is full.
module macro_instruction_expander (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  opcode_i,
  input  logic [3:0]  reg_first_i,
  input  logic [3:0]  reg_second_i,
  input  logic [3:0]  reg_third_i,
  input  logic [7:0]  immediate_i,
  input  logic [15:0] target_address_i,
  output logic        result_strobe_o,
  output logic [15:0] machine_word_o,
  output logic        last_word_o
);
  import mie_pkg::*;

  seq_t front_seq;
  seq_t queue_seq;
  logic queue_valid;
  logic queue_full;
  logic accept;
  logic push;
  logic pop;

  // Take a beat whenever the queue has room.
  assign busy   = queue_full;
  assign accept = start && !busy;
  // Drop instructions that expand to nothing instead of queuing them.
  assign push   = accept && (front_seq.len != '0);

  mie_front u_front (
    .opcode_i         (opcode_i),
    .reg_first_i      (reg_first_i),
    .reg_second_i     (reg_second_i),
    .reg_third_i      (reg_third_i),
    .immediate_i      (immediate_i),
    .target_address_i (target_address_i),
    .seq_o            (front_seq)
  );

  mie_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_seq),
    .pop_i   (pop),
    .rdata_o (queue_seq),
    .valid_o (queue_valid),
    .full_o  (queue_full)
  );

  // Advance through the queued sequence one word per cycle.
  mie_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seq_i       (queue_seq),
    .seq_valid_i (queue_valid),
    .pop_o       (pop),
    .strobe_o    (result_strobe_o),
    .word_o      (machine_word_o),
    .last_o      (last_word_o)
  );

  // The last-word flag only accompanies a valid word.
  `ASSERT_IMPLIES(a_last_has_strobe, clk_i, rst_ni, last_word_o, result_strobe_o)
  // A run of words is never broken before its last word.
  `ASSERT_NEXT(a_run_contiguous, clk_i, rst_ni, result_strobe_o && !last_word_o, result_strobe_o)
  // A full queue means the sequencer is busy emitting.
  `ASSERT_IMPLIES(a_full_means_emitting, clk_i, rst_ni, busy, result_strobe_o)

endmodule

FILE: hdl/mie_front.sv
// Front end: classifies one decoded instruction and builds its word sequence.
// Depends on mie_pkg.
module mie_front (
  input  logic [4:0]      opcode_i,
  input  logic [3:0]      reg_first_i,
  input  logic [3:0]      reg_second_i,
  input  logic [3:0]      reg_third_i,
  input  logic [7:0]      immediate_i,
  input  logic [15:0]     target_address_i,
  output mie_pkg::seq_t   seq_o
);
  import mie_pkg::*;

  logic [7:0] alo;
  logic [7:0] ahi;
  logic [3:0] rs;

  assign alo = target_address_i[7:0];
  assign ahi = target_address_i[15:8];
  assign rs  = (opcode_i == OpJz || opcode_i == OpJnz) ? reg_first_i : 4'h0;

  always_comb begin
    seq_o = '0;
    if (opcode_i inside {[OpAluLo:OpAluHi], OpLoad, OpStore}) begin
      seq_o.words[0] = {opcode_i[3:0], reg_first_i, reg_second_i, reg_third_i};
      seq_o.len      = 3'd1;
    end else begin
      case (opcode_i)
        OpMovi: begin
          seq_o.words[0] = {4'h8, reg_first_i, immediate_i};
          seq_o.len      = 3'd1;
        end
        OpJmp, OpJz, OpJnz, OpCall: begin
          seq_o.words[0] = {8'h8C, alo};
          seq_o.words[1] = {8'h8F, ahi};
          seq_o.words[2] = {opcode_i[3:0], 8'hFC, rs};
          seq_o.len      = 3'd3;
        end
        OpRet: begin
          seq_o.words[0] = 16'hF000;
          seq_o.len      = 3'd1;
        end
        OpPush: begin
          seq_o.words[0] = 16'h8F01;
          seq_o.words[1] = 16'h1EEF;
          seq_o.words[2] = {4'hA, reg_first_i, 8'hEE};
          seq_o.len      = 3'd3;
        end
        OpPop: begin
          seq_o.words[0] = {4'h9, reg_first_i, 8'hEE};
          seq_o.words[1] = 16'h8F01;
          seq_o.words[2] = 16'h0EEF;
          seq_o.len      = 3'd3;
        end
        OpPushi: begin
          seq_o.words[0] = {8'h8C, immediate_i};
          seq_o.words[1] = 16'h8F01;
          seq_o.words[2] = 16'h1EEF;
          seq_o.words[3] = 16'hACEE;
          seq_o.len      = 3'd4;
        end
        OpMov: begin
          seq_o.words[0] = {4'h2, reg_first_i, reg_second_i, reg_second_i};
          seq_o.len      = 3'd1;
        end
        OpInc: begin
          seq_o.words[0] = 16'h8F01;
          seq_o.words[1] = {4'h0, reg_first_i, reg_first_i, 4'hF};
          seq_o.len      = 3'd2;
        end
        OpDec: begin
          seq_o.words[0] = 16'h8F01;
          seq_o.words[1] = {4'h1, reg_first_i, reg_first_i, 4'hF};
          seq_o.len      = 3'd2;
        end
        OpClr: begin
          seq_o.words[0] = {4'h8, reg_first_i, 8'h00};
          seq_o.len      = 3'd1;
        end
        OpJe, OpJne: begin
          seq_o.words[0] = {8'h1F, reg_first_i, reg_second_i};
          seq_o.words[1] = 16'h2DFF;
          seq_o.words[2] = {8'h8C, alo};
          seq_o.words[3] = {8'h8F, ahi};
          seq_o.words[4] = (opcode_i == OpJe) ? 16'hCFCD : 16'hDFCD;
          seq_o.len      = 3'd5;
        end
        OpJlt: begin
          seq_o.words[0] = {8'h1F, reg_first_i, reg_second_i};
          seq_o.words[1] = 16'h8C01;
          seq_o.words[2] = 16'h7DDC;
          seq_o.words[3] = {8'h8C, alo};
          seq_o.words[4] = {8'h8F, ahi};
          seq_o.words[5] = 16'hDFCD;
          seq_o.len      = 3'd6;
        end
        default: seq_o = '0;
      endcase
    end
  end

endmodule

FILE: hdl/mie_queue.sv
// Two-entry queue of expanded sequences between front and back ends.
// Depends on mie_pkg.
module mie_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mie_pkg::seq_t wdata_i,
  input  logic          pop_i,
  output mie_pkg::seq_t rdata_o,
  output logic          valid_o,
  output logic          full_o
);
  import mie_pkg::*;

  seq_t       mem_q [QDepth];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'(QDepth));
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hdl/mie_back.sv
// Back end: steps through one queued sequence, one word per cycle.
// Depends on mie_pkg.
module mie_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mie_pkg::seq_t seq_i,
  input  logic          seq_valid_i,
  output logic          pop_o,
  output logic          strobe_o,
  output logic [15:0]   word_o,
  output logic          last_o
);
  import mie_pkg::*;

  seq_t            cur_q;
  logic            valid_q;
  logic [IdxW-1:0] idx_q;
  logic            last;

  assign last     = valid_q && (idx_q == (cur_q.len - 3'd1));
  assign pop_o    = seq_valid_i && (!valid_q || last);
  assign strobe_o = valid_q;
  assign word_o   = cur_q.words[idx_q];
  assign last_o   = last;

  // Load payload on each pop.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= seq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q) begin
      if (last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

endmodule
